// ===== design/srbm_pkg.sv =====
// Shared types, constants and widths of the segmented RMS bar meter.
package srbm_pkg;

    localparam int DEF_BAR_COUNT  = 64;
    localparam int DEF_MAX_WINDOW = 1024;

    localparam int SUM_W   = 41;
    localparam int RAD_W   = SUM_W + (SUM_W % 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam int SREM_W  = ROOT_W + 2;
    localparam int GAIN_W  = 12;
    localparam int PROD_W  = ROOT_W + GAIN_W;
    localparam int STEP_W  = $clog2(SUM_W);

    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0] REG_SPB     = 2'd0;
    localparam logic [1:0] REG_GAIN    = 2'd1;
    localparam logic [1:0] REG_CEILING = 2'd2;

    localparam logic [10:0] RST_SPB     = 11'd750;
    localparam logic [11:0] RST_GAIN    = 12'd896;
    localparam logic [15:0] RST_CEILING = 16'd58982;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               frame_start;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  bar_index;
        logic [15:0] bar_height;
        logic        last_bar;
    } t_out_item;

    typedef struct packed {
        logic [10:0]       spb;
        logic [GAIN_W-1:0] gain;
        logic [15:0]       ceiling;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic mult;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic win_done;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_DIV,
        S_ROOT_INIT,
        S_SQRT,
        S_MULT,
        S_EMIT
    } t_state;

endpackage

// ===== design/segmented_rms_bar_meter_unit.sv =====
// Top level of the segmented RMS bar meter: register file, sequencer and datapath.
// Takes one Q1.15 sample per item and sums its square into the current window; when the
// window reaches samples_per_bar samples (0 counts as 1, capped at MAX_WINDOW) it emits one
// bar with height min(floor(isqrt(sum / count) * gain / 256), ceiling), 32768 = 1.0. An
// item with frame_start set clears the window and the bar count first; after BAR_COUNT bars
// items are taken and dropped until the next frame_start. Items are handled one at a time:
// a new item is accepted once the previous one has been squared and accumulated and, if it
// closed a window, has passed the one-bit-per-cycle divider and square root unit, the gain
// multiply and any wait for the output register to be freed by o_out_valid being taken.
// A finished bar waiting at the output does not block new items.
module segmented_rms_bar_meter_unit
    import srbm_pkg::*;
#(
    parameter int BAR_COUNT  = DEF_BAR_COUNT,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spb     <= RST_SPB;
            r_cfg.gain    <= RST_GAIN;
            r_cfg.ceiling <= RST_CEILING;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_SPB:     r_cfg.spb     <= pwdata[10:0];
                REG_GAIN:    r_cfg.gain    <= pwdata[GAIN_W-1:0];
                REG_CEILING: r_cfg.ceiling <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SPB:     prdata = APB_DW'(r_cfg.spb);
            REG_GAIN:    prdata = APB_DW'(r_cfg.gain);
            REG_CEILING: prdata = APB_DW'(r_cfg.ceiling);
            default:     prdata = '0;
        endcase
    end

    srbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srbm_dp #(
        .BAR_COUNT  (BAR_COUNT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg       (r_cfg),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/srbm_ctrl.sv =====
// Sequencer of the bar meter: steps the datapath through square, accumulate, divide, root, gain and emit.
module srbm_ctrl
    import srbm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACCUM;
            end
            S_ACCUM: begin
                // drop the item once the frame holds all its bars
                if (i_stat.full) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.accum = 1'b1;
                    n_step      = '0;
                    n_state     = i_stat.win_done ? S_DIV : S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = S_ROOT_INIT;
                end
            end
            S_ROOT_INIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_step          = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_W - 1)) begin
                    n_state = S_MULT;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/srbm_dp.sv =====
// Datapath of the bar meter: square sum, bit-serial divider, bit-serial root, gain and clamp.
module srbm_dp
    import srbm_pkg::*;
#(
    parameter int BAR_COUNT  = DEF_BAR_COUNT,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  t_cfg      i_cfg,
    input  t_in_item  i_in_item,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int BAR_W = $clog2(BAR_COUNT + 1);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    // control state
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;
    logic [BAR_W-1:0]  r_bar;
    logic              r_out_valid;

    // payload registers
    logic [15:0]       r_mag;
    logic              r_frame;
    logic [31:0]       r_sq;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [RAD_W-1:0]  r_rad;
    logic [SREM_W-1:0] r_srem;
    logic [ROOT_W-1:0] r_root;
    logic [PROD_W-1:0] r_prod;
    t_out_item         r_out;

    logic [15:0]       n_mag;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W:0]    n_count;
    logic [CNT_W-1:0]  eff_len;
    logic [CNT_W:0]    div_t;
    logic              div_ge;
    logic [SREM_W+1:0] sq_t;
    logic [SREM_W+1:0] sq_trial;
    logic              sq_ge;
    logic [PROD_W-9:0] scaled;
    logic [15:0]       height;

    assign n_mag = i_in_item.sample[15] ? 16'(-i_in_item.sample) : 16'(i_in_item.sample);

    // saturate the running sum at its full-scale value
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
    assign n_sum   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    assign n_count = {1'b0, r_count} + 1'b1;

    always_comb begin
        if (i_cfg.spb == '0) begin
            eff_len = CNT_W'(1);
        end else if (32'(i_cfg.spb) > 32'(MAX_WINDOW)) begin
            eff_len = CNT_W'(MAX_WINDOW);
        end else begin
            eff_len = CNT_W'(i_cfg.spb);
        end
    end

    assign div_t  = {r_rem, r_quo[SUM_W-1]};
    assign div_ge = div_t >= {1'b0, r_count};

    assign sq_t     = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = (SREM_W + 2)'({r_root, 2'b01});
    assign sq_ge    = sq_t >= sq_trial;

    assign scaled = r_prod[PROD_W-1:8];
    assign height = (scaled > (PROD_W - 8)'(i_cfg.ceiling)) ? i_cfg.ceiling : scaled[15:0];

    assign o_stat.full     = (32'(r_bar) >= 32'(BAR_COUNT));
    assign o_stat.win_done = (n_count >= {1'b0, eff_len});
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_bar       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.square && r_frame) begin
                r_sum   <= '0;
                r_count <= '0;
                r_bar   <= '0;
            end
            if (i_cmd.accum) begin
                r_sum   <= n_sum;
                r_count <= n_count[CNT_W-1:0];
            end
            if (i_cmd.emit) begin
                r_sum       <= '0;
                r_count     <= '0;
                r_bar       <= r_bar + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag   <= n_mag;
            r_frame <= i_in_item.frame_start;
        end
        if (i_cmd.square) begin
            r_sq <= r_mag * r_mag;
        end
        if (i_cmd.accum) begin
            r_quo <= n_sum;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? CNT_W'(div_t - {1'b0, r_count}) : div_t[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], div_ge};
        end
        if (i_cmd.sqrt_init) begin
            r_rad  <= RAD_W'(r_quo);
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad  <= r_rad << 2;
            r_srem <= sq_ge ? SREM_W'(sq_t - sq_trial) : sq_t[SREM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], sq_ge};
        end
        if (i_cmd.mult) begin
            r_prod <= PROD_W'(r_root) * PROD_W'(i_cfg.gain);
        end
        if (i_cmd.emit) begin
            r_out.bar_index  <= 6'(r_bar);
            r_out.bar_height <= height;
            r_out.last_bar   <= (32'(r_bar) == 32'(BAR_COUNT - 1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
